// ----- hdl/tid_pkg.sv -----
// Shared types and constants for the tagged indexed deque.
// Used by the controller, the datapath and the top level.
`default_nettype none
package tid_pkg;

	typedef enum logic [3:0] {
		ACT_PUSH_BACK  = 4'd0,
		ACT_PUSH_FRONT = 4'd1,
		ACT_POP_FRONT  = 4'd2,
		ACT_POP_BACK   = 4'd3,
		ACT_PEEK_FRONT = 4'd4,
		ACT_PEEK_BACK  = 4'd5,
		ACT_GET_AT     = 4'd6,
		ACT_INSERT_AT  = 4'd7,
		ACT_REMOVE_AT  = 4'd8,
		ACT_REVERSE    = 4'd9,
		ACT_FIND       = 4'd10,
		ACT_CLEAR      = 4'd11
	} action_t;

	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_EMPTY    = 3'd1;
	localparam logic [2:0] ST_RANGE    = 3'd2;
	localparam logic [2:0] ST_FULL     = 3'd3;
	localparam logic [2:0] ST_NOTFOUND = 3'd4;

	localparam int TAG_W = 15;
	localparam int VAL_W = 64;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DECODE,
		S_READ,
		S_SHIFT_RD,
		S_SHIFT_WR,
		S_REV_RD_A,
		S_REV_RD_B,
		S_REV_WR,
		S_REV_WR2,
		S_FIND_RD,
		S_FIND_CMP,
		S_DONE
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic latch_in;     // capture the input transaction
		logic set_plan;     // work out the walk for this action
		logic rd_a;         // read the memory at walk pointer a
		logic rd_b;         // read the memory at walk pointer b
		logic hold_a;       // keep read data as entry a
		logic wr_shift;     // write the shifted entry
		logic wr_rev;       // write the swap pair, one per cycle
		logic rev_second;   // second half of a swap write
		logic step;         // advance the walk
		logic cmp;          // compare read data for find
		logic commit;       // update pointers and build the result
		logic take_result;  // capture the result read
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic       need_read;  // end read or indexed read
		logic       shift;      // insert or remove walk
		logic       reverse;
		logic       find;
		logic       walk_done;
		logic       hit;
		logic       remove_read;
	} stat_t;

endpackage
`default_nettype wire

// ----- hdl/tid_ctrl.sv -----
// Controller of the tagged indexed deque: sequences each action.
// Depends on tid_pkg.
`default_nettype none
module tid_ctrl
	import tid_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  in_valid,
	output logic       in_ready,
	output logic       out_valid,
	input  wire logic  out_ready,
	input  wire stat_t st,
	output cmd_t       cmd
);

	state_t state_q, state_d;
	logic   out_valid_q, out_valid_d;

	// State register and output valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			out_valid_q <= out_valid_d;
		end
	end

	assign out_valid = out_valid_q;
	// A new transaction may start while the previous result waits, since the
	// result sits in its own register; it must have gone before commit.
	assign in_ready = (state_q == S_IDLE);

	// Next state and commands.
	always_comb begin
		state_d     = state_q;
		cmd         = '0;
		out_valid_d = out_valid_q && !out_ready;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.latch_in = 1'b1;
					state_d      = S_DECODE;
				end
			end
			S_DECODE: begin
				cmd.set_plan = 1'b1;
				if (st.need_read || st.remove_read) begin
					cmd.rd_a = 1'b1;
					state_d  = S_READ;
				end else if (st.shift) begin
					state_d = S_SHIFT_RD;
				end else if (st.reverse) begin
					state_d = S_REV_RD_A;
				end else if (st.find) begin
					state_d = S_FIND_RD;
				end else begin
					state_d = S_DONE;
				end
			end
			S_READ: begin
				cmd.take_result = 1'b1;
				state_d = st.shift ? S_SHIFT_RD : S_DONE;
			end
			S_SHIFT_RD: begin
				if (st.walk_done) begin
					state_d = S_DONE;
				end else begin
					cmd.rd_a = 1'b1;
					state_d  = S_SHIFT_WR;
				end
			end
			S_SHIFT_WR: begin
				cmd.wr_shift = 1'b1;
				cmd.step     = 1'b1;
				state_d      = S_SHIFT_RD;
			end
			S_REV_RD_A: begin
				if (st.walk_done) begin
					state_d = S_DONE;
				end else begin
					cmd.rd_a = 1'b1;
					state_d  = S_REV_RD_B;
				end
			end
			S_REV_RD_B: begin
				cmd.hold_a = 1'b1;
				cmd.rd_b   = 1'b1;
				state_d    = S_REV_WR;
			end
			// Entry b goes to position a first, then the held entry a to b.
			S_REV_WR: begin
				cmd.wr_rev = 1'b1;
				state_d    = S_REV_WR2;
			end
			S_REV_WR2: begin
				cmd.wr_rev     = 1'b1;
				cmd.rev_second = 1'b1;
				cmd.step       = 1'b1;
				state_d        = S_REV_RD_A;
			end
			S_FIND_RD: begin
				if (st.walk_done) begin
					state_d = S_DONE;
				end else begin
					cmd.rd_a = 1'b1;
					state_d  = S_FIND_CMP;
				end
			end
			S_FIND_CMP: begin
				cmd.cmp = 1'b1;
				if (st.hit) begin
					state_d = S_DONE;
				end else begin
					cmd.step = 1'b1;
					state_d  = S_FIND_RD;
				end
			end
			S_DONE: begin
				if (!out_valid_q || out_ready) begin
					cmd.commit  = 1'b1;
					out_valid_d = 1'b1;
					state_d     = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

endmodule
`default_nettype wire

// ----- hdl/tid_dpath.sv -----
// Datapath of the tagged indexed deque: entry memory, pointers, walk
// counters and the result register. Depends on tid_pkg.
`default_nettype none
module tid_dpath
	import tid_pkg::*;
#(
	parameter int CAPACITY = 64
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic [3:0]           action,
	input  wire logic signed [7:0]    item_index,
	input  wire logic [TAG_W-1:0]     entry_tag,
	input  wire logic [VAL_W-1:0]     entry_value,
	input  wire cmd_t                 cmd,
	output stat_t                     st,
	output logic [TAG_W-1:0]          result_tag,
	output logic [VAL_W-1:0]          result_value,
	output logic [5:0]                found_position,
	output logic [2:0]                status,
	output logic [6:0]                entry_count
);

	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int XW = (CW > 7) ? CW : 7;
	localparam int EW = TAG_W + VAL_W;
	localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

	// Entry memory: one write and one registered read a cycle.
	logic [EW-1:0] mem_q [CAPACITY];
	logic [EW-1:0] rd_q, ent_a_q;

	logic [AW-1:0] front_q;
	logic [CW-1:0] count_q;

	// Captured transaction.
	logic [3:0]        act_q;
	logic signed [7:0] idx_q;
	logic [EW-1:0]     new_q;

	// Walk state: logical positions.
	logic [CW-1:0] pa_q, pb_q, lim_q, pos_q;
	logic          hit_q;
	logic [EW-1:0] res_ent_q;
	logic          rev_q, shift_up_q, shift_q;

	// New entry placement and result fields.
	logic          new_write;
	logic [AW-1:0] new_slot;
	logic [2:0]    st_code;
	logic [CW-1:0] st_count_next;

	logic full, empty;
	assign full  = (count_q >= CAP_C);
	assign empty = (count_q == '0);

	// Logical position to slot, with wrap.
	function automatic logic [AW-1:0] slot(input logic [AW-1:0] fr, input logic [CW-1:0] p);
		logic [CW:0] s;
		s = {1'b0, p} + (CW+1)'(fr);
		if (s >= (CW+1)'(CAPACITY)) s = s - (CW+1)'(CAPACITY);
		return s[AW-1:0];
	endfunction

	// Index classification, compared wide enough for any index and count.
	logic idx_le0, idx_neg, idx_ge_cnt, idx_ge_last;
	logic [CW-1:0] last;
	logic [XW-1:0] idx_mag;
	assign last        = count_q - CW'(1);
	assign idx_neg     = idx_q[7];
	assign idx_le0     = idx_neg || (idx_q == 8'sd0);
	assign idx_mag     = XW'(idx_q[6:0]);
	assign idx_ge_cnt  = !idx_neg && (idx_mag >= XW'(count_q));
	assign idx_ge_last = !idx_neg && (idx_mag >= XW'(last));

	// Decoded plan for the action.
	logic is_ins_mid, is_rem, is_rd;
	logic [CW-1:0] rem_pos, rd_pos;
	always_comb begin
		is_ins_mid = (act_q == ACT_INSERT_AT) && !full && !idx_le0 && !idx_ge_cnt;
		is_rem  = !empty && ((act_q == ACT_POP_FRONT) || (act_q == ACT_POP_BACK)
			|| (act_q == ACT_REMOVE_AT));
		rem_pos = '0;
		if (act_q == ACT_POP_BACK) rem_pos = last;
		else if (act_q == ACT_REMOVE_AT) begin
			if (idx_le0) rem_pos = '0;
			else if (idx_ge_last) rem_pos = last;
			else rem_pos = CW'(idx_q[6:0]);
		end
		is_rd  = 1'b0;
		rd_pos = '0;
		if (!empty) begin
			if (act_q == ACT_PEEK_FRONT) is_rd = 1'b1;
			if (act_q == ACT_PEEK_BACK) begin
				is_rd  = 1'b1;
				rd_pos = last;
			end
			if (act_q == ACT_GET_AT && !idx_neg && !idx_ge_cnt) begin
				is_rd  = 1'b1;
				rd_pos = CW'(idx_q[6:0]);
			end
		end
	end

	// Status towards the controller.
	always_comb begin
		st             = '0;
		st.need_read   = is_rd;
		st.remove_read = is_rem;
		st.shift       = shift_q || is_ins_mid || (is_rem && rem_pos != '0 && rem_pos != last);
		st.reverse     = (act_q == ACT_REVERSE);
		st.find        = (act_q == ACT_FIND);
		st.walk_done   = rev_q ? (pa_q >= pb_q) : (pa_q == lim_q);
		st.hit         = (rd_q == new_q);
	end

	// Memory port: address chosen by the command. The first read of an
	// action is issued while the walk pointers are still being loaded.
	logic [AW-1:0] rd_addr, wr_addr;
	logic [EW-1:0] wr_data;
	logic          wr_en;
	logic [CW-1:0] src_pos;
	always_comb begin
		src_pos = shift_up_q ? pa_q - CW'(1) : pa_q + CW'(1);
		if (cmd.set_plan) rd_addr = slot(front_q, is_rem ? rem_pos : rd_pos);
		else if (cmd.rd_b) rd_addr = slot(front_q, pb_q);
		else if (shift_q && !rev_q) rd_addr = slot(front_q, src_pos);
		else rd_addr = slot(front_q, pa_q);
		wr_en   = cmd.wr_shift || cmd.wr_rev || (cmd.commit && new_write);
		wr_addr = slot(front_q, pa_q);
		wr_data = rd_q;
		if (cmd.wr_rev) begin
			wr_addr = cmd.rev_second ? slot(front_q, pb_q) : slot(front_q, pa_q);
			wr_data = cmd.rev_second ? ent_a_q : rd_q;
		end
		if (cmd.commit) begin
			wr_addr = new_slot;
			wr_data = new_q;
		end
	end

	// Slot that a push or an insert writes.
	always_comb begin
		new_write = 1'b0;
		new_slot  = slot(front_q, count_q);
		if (!full) begin
			case (act_q)
				ACT_PUSH_BACK: new_write = 1'b1;
				ACT_PUSH_FRONT: begin
					new_write = 1'b1;
					new_slot  = (front_q == '0) ? AW'(CAPACITY - 1) : front_q - AW'(1);
				end
				ACT_INSERT_AT: begin
					new_write = 1'b1;
					if (idx_le0)
						new_slot = (front_q == '0) ? AW'(CAPACITY - 1) : front_q - AW'(1);
					else if (!idx_ge_cnt) new_slot = slot(front_q, CW'(idx_q[6:0]));
				end
				default: new_write = 1'b0;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) mem_q[wr_addr] <= wr_data;
		rd_q <= mem_q[rd_addr];
	end

	// Walk control and captured data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q    <= '0;
			count_q    <= '0;
			rev_q      <= 1'b0;
			shift_q    <= 1'b0;
			shift_up_q <= 1'b0;
			hit_q      <= 1'b0;
		end else begin
			if (cmd.latch_in) begin
				rev_q   <= 1'b0;
				shift_q <= 1'b0;
				hit_q   <= 1'b0;
			end
			if (cmd.set_plan) begin
				rev_q      <= (act_q == ACT_REVERSE);
				shift_q    <= is_ins_mid || (is_rem && rem_pos != '0 && rem_pos != last);
				shift_up_q <= is_ins_mid;
			end
			if (cmd.cmp && st.hit) hit_q <= 1'b1;
			if (cmd.commit) begin
				case (act_q)
					ACT_PUSH_BACK, ACT_PUSH_FRONT, ACT_INSERT_AT: begin
						if (!full) begin
							count_q <= count_q + CW'(1);
							if (act_q == ACT_PUSH_FRONT || (act_q == ACT_INSERT_AT && idx_le0))
								front_q <= new_slot;
						end
					end
					ACT_POP_FRONT, ACT_POP_BACK, ACT_REMOVE_AT: begin
						if (!empty) begin
							count_q <= count_q - CW'(1);
							if (rem_pos == '0)
								front_q <= (front_q == AW'(CAPACITY - 1)) ? '0 : front_q + AW'(1);
						end
					end
					ACT_CLEAR: begin
						count_q <= '0;
						front_q <= '0;
					end
					default: ;
				endcase
			end
		end
	end

	// Payload registers: transaction, walk pointers, result.
	always_ff @(posedge clk) begin
		if (cmd.latch_in) begin
			act_q <= action;
			idx_q <= item_index;
			new_q <= {entry_tag, entry_value};
		end
		if (cmd.set_plan) begin
			res_ent_q <= '0;
			pos_q     <= '0;
			if (is_ins_mid) begin
				pa_q  <= count_q;
				lim_q <= CW'(idx_q[6:0]);
			end else if (is_rem) begin
				pa_q  <= rem_pos;
				lim_q <= last;
			end else if (act_q == ACT_FIND) begin
				pa_q  <= '0;
				lim_q <= count_q;
			end else begin
				pa_q  <= is_rd ? rd_pos : '0;
				lim_q <= '0;
			end
			pb_q <= (act_q == ACT_REVERSE && !empty) ? last : '0;
		end
		if (cmd.hold_a) ent_a_q <= rd_q;
		if (cmd.take_result) res_ent_q <= rd_q;
		if (cmd.step) begin
			if (rev_q) begin
				pa_q <= pa_q + CW'(1);
				pb_q <= pb_q - CW'(1);
			end else if (shift_up_q) pa_q <= pa_q - CW'(1);
			else pa_q <= pa_q + CW'(1);
		end
		if (cmd.cmp && st.hit) pos_q <= pa_q;
		if (cmd.commit) begin
			result_tag     <= res_ent_q[EW-1:VAL_W];
			result_value   <= res_ent_q[VAL_W-1:0];
			found_position <= 6'(pos_q);
			entry_count    <= 7'(st_count_next);
			status         <= st_code;
		end
	end

	// Result status and count after the action.
	always_comb begin
		st_code       = ST_OK;
		st_count_next = count_q;
		case (act_q)
			ACT_PUSH_BACK, ACT_PUSH_FRONT, ACT_INSERT_AT:
				if (full) st_code = ST_FULL; else st_count_next = count_q + CW'(1);
			ACT_POP_FRONT, ACT_POP_BACK, ACT_REMOVE_AT, ACT_PEEK_FRONT, ACT_PEEK_BACK:
				if (empty) st_code = ST_EMPTY;
				else if (is_rem) st_count_next = last;
			ACT_GET_AT:
				if (empty) st_code = ST_EMPTY;
				else if (!is_rd) st_code = ST_RANGE;
			ACT_FIND: if (!hit_q) st_code = ST_NOTFOUND;
			ACT_CLEAR: st_count_next = '0;
			default: st_code = ST_OK;
		endcase
	end

endmodule
`default_nettype wire

// ----- hdl/tagged_indexed_deque.sv -----
// Top level of the tagged indexed deque: controller plus datapath.
// Depends on tid_pkg, tid_ctrl and tid_dpath.
`default_nettype none
// An ordered store of up to CAPACITY tagged entries held in a circular
// buffer in one memory with one read and one write a cycle. A push, a clear
// or a refused push goes from decode straight to its result, and a pop, a
// peek or a read passes through a memory read first; the next transaction is
// taken in the cycle that the result appears. Insert and remove at an interior
// index also walk over each entry moved, reverse over each swapped pair and
// find over each entry examined, all paced by the one memory read port. One
// transaction is worked on at a time; the result waits in its own register
// while the next one is taken, and a waiting result holds back the next commit.
module tagged_indexed_deque
	import tid_pkg::*;
#(
	parameter int CAPACITY = 64
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic [3:0]        action,
	input  wire logic signed [7:0] item_index,
	input  wire logic [TAG_W-1:0]  entry_tag,
	input  wire logic [VAL_W-1:0]  entry_value,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output logic [TAG_W-1:0]       result_tag,
	output logic [VAL_W-1:0]       result_value,
	output logic [5:0]             found_position,
	output logic [2:0]             status,
	output logic [6:0]             entry_count
);

	cmd_t  cmd;
	stat_t st;

	tid_ctrl u_ctrl (
		.clk, .arst_n, .in_valid, .in_ready, .out_valid, .out_ready,
		.st, .cmd
	);

	tid_dpath #(.CAPACITY(CAPACITY)) u_dpath (
		.clk, .arst_n, .action, .item_index, .entry_tag, .entry_value,
		.cmd, .st, .result_tag, .result_value, .found_position, .status,
		.entry_count
	);

	// A result is only produced when the output register is free.
	a_commit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> (!out_valid || out_ready))
		else $error("result overwritten");

	// No new transaction while one is in progress.
	a_one_at_time: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.latch_in |=> !in_ready)
		else $error("transaction overlap");

	// The entry count never exceeds capacity.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (int'(entry_count) <= CAPACITY))
		else $error("count beyond capacity");

endmodule
`default_nettype wire

// ----- bench/tb_top.sv -----
// Self-checking testbench for the tagged indexed deque.
// Depends on tid_pkg and the tagged_indexed_deque top level; needs no files.
`timescale 1ns / 1ps
`default_nettype none
module tb_top
	import tid_pkg::*;
();

	localparam int DEPTH = 64;
	localparam int CYCLE_LIMIT = 600000;

	typedef struct {
		logic [3:0]        act;
		logic signed [7:0] idx;
		logic [14:0]       tag;
		logic [63:0]       val;
		bit                typed;
		logic [2:0]        exp_status;
		logic [6:0]        exp_count;
	} stim_row_t;

	typedef struct {
		logic [14:0] tag;
		logic [63:0] val;
		logic [5:0]  pos;
		logic [2:0]  status;
		logic [6:0]  count;
	} deque_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [3:0] action = '0;
	logic signed [7:0] item_index = '0;
	logic [14:0] entry_tag = '0;
	logic [63:0] entry_value = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [14:0] result_tag;
	logic [63:0] result_value;
	logic [5:0] found_position;
	logic [2:0] status;
	logic [6:0] entry_count;

	// Shadow copy of the deque contents, kept as a plain ordered list.
	logic [14:0] shadow_tag[$];
	logic [63:0] shadow_val[$];
	deque_result_t awaited_results[$];
	int fail_count = 0;
	int cycle_count = 0;
	bit stall_long = 1'b0;

	tagged_indexed_deque #(.CAPACITY(DEPTH)) uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.action(action), .item_index(item_index),
		.entry_tag(entry_tag), .entry_value(entry_value),
		.out_valid(out_valid), .out_ready(out_ready),
		.result_tag(result_tag), .result_value(result_value),
		.found_position(found_position), .status(status),
		.entry_count(entry_count)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Applies one transaction to the shadow list and returns its result.
	function automatic deque_result_t deque_apply(logic [3:0] act, logic signed [7:0] idx,
			logic [14:0] tag, logic [63:0] val);
		deque_result_t r;
		int n;
		int k;
		logic [14:0] tt;
		logic [63:0] tv;
		r = '{default: '0};
		n = shadow_tag.size();
		case (act)
			ACT_PUSH_BACK, ACT_PUSH_FRONT, ACT_INSERT_AT: begin
				if (n >= DEPTH) begin
					r.status = ST_FULL;
				end else begin
					if (act == ACT_PUSH_BACK) k = n;
					else if (act == ACT_PUSH_FRONT) k = 0;
					else k = (idx <= 0) ? 0 : ((idx >= n) ? n : int'(idx));
					shadow_tag.insert(k, tag);
					shadow_val.insert(k, val);
				end
			end
			ACT_POP_FRONT, ACT_POP_BACK, ACT_REMOVE_AT: begin
				if (n == 0) begin
					r.status = ST_EMPTY;
				end else begin
					if (act == ACT_POP_FRONT) k = 0;
					else if (act == ACT_POP_BACK) k = n - 1;
					else k = (idx <= 0) ? 0 : ((idx >= n - 1) ? n - 1 : int'(idx));
					r.tag = shadow_tag[k];
					r.val = shadow_val[k];
					shadow_tag.delete(k);
					shadow_val.delete(k);
				end
			end
			ACT_PEEK_FRONT, ACT_PEEK_BACK, ACT_GET_AT: begin
				if (n == 0) begin
					r.status = ST_EMPTY;
				end else if (act == ACT_GET_AT && (idx < 0 || idx >= n)) begin
					r.status = ST_RANGE;
				end else begin
					k = (act == ACT_PEEK_FRONT) ? 0 : ((act == ACT_PEEK_BACK) ? n - 1 : int'(idx));
					r.tag = shadow_tag[k];
					r.val = shadow_val[k];
				end
			end
			ACT_REVERSE: begin
				for (k = 0; k < n / 2; k++) begin
					tt = shadow_tag[k];
					tv = shadow_val[k];
					shadow_tag[k] = shadow_tag[n - 1 - k];
					shadow_val[k] = shadow_val[n - 1 - k];
					shadow_tag[n - 1 - k] = tt;
					shadow_val[n - 1 - k] = tv;
				end
			end
			ACT_FIND: begin
				r.status = ST_NOTFOUND;
				for (k = 0; k < n; k++) begin
					if (shadow_tag[k] === tag && shadow_val[k] === val) begin
						r.status = ST_OK;
						r.pos = k[5:0];
						break;
					end
				end
			end
			ACT_CLEAR: begin
				shadow_tag.delete();
				shadow_val.delete();
			end
			default: ;
		endcase
		r.count = 7'(shadow_tag.size());
		return r;
	endfunction

	// Offers one transaction after a random gap and waits for its acceptance.
	// Ready is registered, so its value at the falling edge holds at the next
	// rising edge.
	task automatic send_transaction(logic [3:0] act, logic signed [7:0] idx,
			logic [14:0] tag, logic [63:0] val, bit typed, logic [2:0] est, logic [6:0] ecnt);
		deque_result_t r;
		int gap;
		bit seen;
		gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		action <= act;
		item_index <= idx;
		entry_tag <= tag;
		entry_value <= val;
		do begin
			@(negedge clk);
			seen = in_ready;
			@(posedge clk);
		end while (!seen);
		r = deque_apply(act, idx, tag, val);
		if (typed && (r.status !== est || r.count !== ecnt)) begin
			$display("%0t: table row disagrees: expected status %0d count %0d, got %0d %0d",
				$time, est, ecnt, r.status, r.count);
			fail_count++;
		end
		awaited_results.push_back(r);
	endtask

	// Random content, biased towards tags and values already held so finds hit.
	task automatic send_random;
		logic [3:0] act;
		logic [14:0] tag;
		logic [63:0] val;
		logic signed [7:0] idx;
		int sel;
		int n;
		sel = $urandom_range(0, 99);
		n = shadow_tag.size();
		if (sel < 30) act = 4'($urandom_range(0, 1));
		else if (sel < 45) act = ACT_INSERT_AT;
		else if (sel < 98) act = 4'($urandom_range(2, 10));
		else act = (sel == 98) ? ACT_CLEAR : 4'($urandom_range(12, 15));
		tag = 15'($urandom());
		val = {$urandom(), $urandom()};
		if (n > 0 && $urandom_range(0, 1)) begin
			sel = $urandom_range(0, n - 1);
			tag = shadow_tag[sel];
			val = shadow_val[sel];
		end
		idx = ($urandom_range(0, 3) == 0) ? 8'($urandom()) : 8'($urandom_range(0, n + 1));
		send_transaction(act, idx, tag, val, 1'b0, '0, '0);
	endtask

	// Receiver: random stalls, plus one long hold-off when asked.
	initial begin
		int wait_cycles;
		bit seen;
		forever begin
			if (stall_long) begin
				out_ready <= 1'b0;
				repeat (300) @(posedge clk);
				stall_long = 1'b0;
			end
			wait_cycles = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
			if (wait_cycles > 0) begin
				out_ready <= 1'b0;
				repeat (wait_cycles) @(posedge clk);
			end
			out_ready <= 1'b1;
			do begin
				@(negedge clk);
				seen = out_valid;
				@(posedge clk);
			end while (!seen);
		end
	end

	// Result checker on every result transaction, sampled before its accepting edge.
	always @(negedge clk) begin
		deque_result_t e;
		if (arst_n && out_valid && out_ready) begin
			if (awaited_results.size() == 0) begin
				$display("%0t: result with nothing awaited: tag %h value %h status %0d",
					$time, result_tag, result_value, status);
				fail_count++;
			end else begin
				e = awaited_results.pop_front();
				if (result_tag !== e.tag || result_value !== e.val
						|| found_position !== e.pos || status !== e.status
						|| entry_count !== e.count) begin
					$display("%0t: mismatch expected tag %h value %h pos %0d status %0d count %0d",
						$time, e.tag, e.val, e.pos, e.status, e.count);
					$display("%0t:          actual   tag %h value %h pos %0d status %0d count %0d",
						$time, result_tag, result_value, found_position, status, entry_count);
					fail_count++;
				end
			end
		end
	end

	// Run limit.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	// Stimulus: directed table, fill-to-full with a held receiver, random part.
	initial begin
		stim_row_t rows[$];
		int i;
		rows = '{
			'{ACT_POP_FRONT, 8'sd0, 15'd0, 64'd0, 1'b1, ST_EMPTY, 7'd0},
			'{ACT_POP_BACK, 8'sd0, 15'd0, 64'd0, 1'b1, ST_EMPTY, 7'd0},
			'{ACT_PEEK_FRONT, 8'sd0, 15'd0, 64'd0, 1'b1, ST_EMPTY, 7'd0},
			'{ACT_PEEK_BACK, 8'sd0, 15'd0, 64'd0, 1'b1, ST_EMPTY, 7'd0},
			'{ACT_GET_AT, 8'sd0, 15'd0, 64'd0, 1'b1, ST_EMPTY, 7'd0},
			'{ACT_REMOVE_AT, -8'sd1, 15'd0, 64'd0, 1'b1, ST_EMPTY, 7'd0},
			'{ACT_FIND, 8'sd0, 15'd0, 64'd0, 1'b1, ST_NOTFOUND, 7'd0},
			'{ACT_REVERSE, 8'sd0, 15'd0, 64'd0, 1'b1, ST_OK, 7'd0},
			'{ACT_PUSH_BACK, 8'sd0, 15'h7fff, 64'hffff_ffff_ffff_ffff, 1'b1, ST_OK, 7'd1},
			'{ACT_REVERSE, 8'sd0, 15'd0, 64'd0, 1'b0, ST_OK, 7'd0},
			'{ACT_PUSH_FRONT, 8'sd0, 15'd0, 64'd0, 1'b1, ST_OK, 7'd2},
			'{ACT_INSERT_AT, -8'sd128, 15'h5555, 64'h5555_aaaa_5555_aaaa, 1'b0, ST_OK, 7'd0},
			'{ACT_INSERT_AT, 8'sd127, 15'h2aaa, 64'haaaa_5555_aaaa_5555, 1'b0, ST_OK, 7'd0},
			'{ACT_INSERT_AT, 8'sd2, 15'h0001, 64'h1, 1'b0, ST_OK, 7'd0},
			'{ACT_GET_AT, -8'sd1, 15'd0, 64'd0, 1'b1, ST_RANGE, 7'd5},
			'{ACT_GET_AT, 8'sd5, 15'd0, 64'd0, 1'b1, ST_RANGE, 7'd5},
			'{ACT_GET_AT, 8'sd2, 15'd0, 64'd0, 1'b0, ST_OK, 7'd0},
			'{ACT_FIND, 8'sd0, 15'h0001, 64'h1, 1'b0, ST_OK, 7'd0},
			'{ACT_FIND, 8'sd0, 15'h0001, 64'h2, 1'b0, ST_OK, 7'd0},
			'{ACT_REVERSE, 8'sd0, 15'd0, 64'd0, 1'b0, ST_OK, 7'd0},
			'{ACT_PEEK_FRONT, 8'sd0, 15'd0, 64'd0, 1'b0, ST_OK, 7'd0},
			'{ACT_PEEK_BACK, 8'sd0, 15'd0, 64'd0, 1'b0, ST_OK, 7'd0},
			'{ACT_REMOVE_AT, 8'sd2, 15'd0, 64'd0, 1'b0, ST_OK, 7'd0},
			'{ACT_REMOVE_AT, 8'sd127, 15'd0, 64'd0, 1'b0, ST_OK, 7'd0},
			'{4'd15, 8'sd0, 15'd0, 64'd0, 1'b1, ST_OK, 7'd3}
		};
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (i = 0; i < rows.size(); i++)
			send_transaction(rows[i].act, rows[i].idx, rows[i].tag, rows[i].val,
				rows[i].typed, rows[i].exp_status, rows[i].exp_count);
		// Hold the receiver off while filling past capacity, so the block stalls.
		stall_long = 1'b1;
		for (i = 0; i < 66; i++)
			send_transaction(4'($urandom_range(0, 1)), 8'sd0, 15'($urandom()),
				{$urandom(), $urandom()}, 1'b0, '0, '0);
		send_transaction(ACT_INSERT_AT, 8'sd10, 15'd0, 64'd0, 1'b1, ST_FULL, 7'd64);
		for (i = 0; i < 12; i++) send_random();
		// Sender pauses until every result has come back.
		in_valid <= 1'b0;
		while (awaited_results.size() != 0) @(posedge clk);
		for (i = 0; i < 450; i++) send_random();
		in_valid <= 1'b0;
		while (awaited_results.size() != 0) @(posedge clk);
		repeat (400) @(posedge clk);
		if (fail_count == 0) $display("Verification passed");
		else $display("Verification failed");
		$finish;
	end
endmodule
`default_nettype wire
